### rtl/cmd5_pkg.sv
// Package with types, constants and round tables for the container MD5 hash engine.
package cmd5_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] SplitAt = 6'd56;

  typedef struct packed {
    logic        last_byte;
    logic [31:0] message_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        length_mismatch;
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_TAIL1,
    ST_TAIL2,
    ST_OUT
  } state_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctl_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8e0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

### rtl/cmd5_round.sv
// Shared MD5 round unit: one round a cycle over 64 rounds, with the chain add on the last.
module cmd5_round
  import cmd5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rnd_ctl_t     ctl,
  input  logic [31:0]  word_in,
  output logic [3:0]   word_idx,
  output logic         busy,
  output logic [127:0] chain
);

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] ca_r, cb_r, cc_r, cd_r;
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic [31:0] f, t, rot;
  logic [4:0]  s;

  assign word_idx = word_sel(rnd_r);
  assign busy = busy_r;
  assign chain = {cd_r, cc_r, cb_r, ca_r};

  always_comb begin
    case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t = a_r + f + sine_k(rnd_r) + word_in;
    s = rot_amt(rnd_r);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r <= '0;
      ca_r <= 32'h67452301; cb_r <= 32'hefcdab89;
      cc_r <= 32'h98badcfe; cd_r <= 32'h10325476;
    end else begin
      if (ctl.init) begin
        ca_r <= 32'h67452301; cb_r <= 32'hefcdab89;
        cc_r <= 32'h98badcfe; cd_r <= 32'h10325476;
      end
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r <= '0;
        a_r <= ca_r; b_r <= cb_r; c_r <= cc_r; d_r <= cd_r;
      end else if (busy_r) begin
        a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) begin
          busy_r <= 1'b0;
          ca_r <= ca_r + d_r; cb_r <= cb_r + b_r + rot;
          cc_r <= cc_r + b_r; cd_r <= cd_r + c_r;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(ctl.start && busy_r))
    else $error("round unit started while busy");
  assert property (@(posedge clk) disable iff (!rst_n) !(ctl.init && busy_r))
    else $error("chain reloaded while busy");
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> rnd_r == 6'd0)
    else $error("round counter not at zero while idle");

endmodule

### rtl/container_md5_hash.sv
// Top level of the container MD5 hash engine: byte buffer, sequencer and output register.
//
// Channel | Direction | Payload
// in_     | input     | in_item_t: data_byte, message_length, last_byte
// out_    | output    | out_item_t: digest_low, digest_high, length_mismatch
//
// A byte that does not complete a 64-byte block or end the message does not stall input.
// A byte that completes a block stalls the input while the block state starts the shared
// round unit, waits for its 64 rounds and then leaves the compress state.
// A last byte stalls the input until its result is taken: one or two tail blocks follow any
// block it completes (none on a mismatch without one), then ST_OUT presents the result.
// Reset is synchronous and active low; it loads the MD5 initial chain and clears control.
// The result sits in the output register while out_stall is high; no new byte is taken then.
module container_md5_hash
  import cmd5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // The partial block lives in a 16-word register file, written a byte at a time.
  logic [31:0] blk_r [BlockWords];
  logic [31:0] seen_r, seen_nxt;
  logic [31:0] decl_r;
  logic        in_msg_r;
  state_t      state_r, state_nxt;
  logic        out_valid_r;
  out_item_t   out_r;
  rnd_ctl_t    ctl;
  logic [3:0]  widx;
  logic        rbusy;
  logic [127:0] chain;
  logic [31:0] word_in;
  logic [31:0] nbits, kword;
  logic [5:0]  len;
  logic [5:0]  wpos;
  logic        accept;
  logic        started_r;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign nbits = {seen_r[28:0], 3'b000};
  assign kword = {2'b00, nbits[31:2]} | 32'd1;
  assign len = seen_r[5:0];

  // The first byte of a message always lands in byte zero of the buffer.
  assign wpos = in_msg_r ? seen_r[5:0] : 6'd0;

  // Tail word assembly. Byte position p of a word maps to buffer bytes or padding.
  function automatic logic [7:0] tail_byte(input logic [5:0] pos, input logic [5:0] n,
                                           input logic [7:0] b);
    logic [7:0] r;
    if (pos < n) r = b;
    else if (pos == n) r = PadMark;
    else r = 8'h00;
    return r;
  endfunction

  always_comb begin
    logic [5:0]  p;
    logic [31:0] w;
    logic [31:0] src;
    logic [3:0]  si;
    word_in = '0;
    si = '0;
    for (int j = 0; j < 4; j++) begin
      unique case (state_r)
        ST_TAIL1: begin
          if (len >= SplitAt) begin
            p = {widx, 2'(j)};
            src = blk_r[widx];
          end else begin
            p = 6'({widx, 2'(j)} - 6'd4);
            si = p[5:2];
            src = blk_r[si];
          end
        end
        default: begin
          p = {widx, 2'(j)};
          src = blk_r[widx];
        end
      endcase
      w[j*8 +: 8] = tail_byte(p, len, src[8*p[1:0] +: 8]);
    end
    unique case (state_r)
      ST_BLOCK: word_in = blk_r[widx];
      ST_TAIL1: begin
        if (len >= SplitAt) word_in = w;
        else if (widx == 4'd0) word_in = nbits;
        else if (widx == 4'd15) word_in = kword;
        else word_in = w;
      end
      ST_TAIL2: begin
        if (widx == 4'd0) word_in = nbits;
        else if (widx == 4'd15) word_in = kword;
        else word_in = '0;
      end
      default: word_in = '0;
    endcase
  end

  cmd5_round u_round (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .word_in(word_in),
    .word_idx(widx), .busy(rbusy), .chain(chain)
  );

  // Sequencer: each compress state starts the unit once and waits for it to finish.
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.init = accept && !in_msg_r;
    seen_nxt = (accept && !in_msg_r) ? 32'd1 : seen_r + 32'd1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (seen_nxt[5:0] == 6'd0) state_nxt = ST_BLOCK;
          else if (in_data.last_byte) begin
            state_nxt = (seen_nxt != (in_msg_r ? decl_r : in_data.message_length))
                        ? ST_OUT : ST_TAIL1;
          end
        end
      end
      ST_BLOCK, ST_TAIL1, ST_TAIL2: begin
        if (!started_r) ctl.start = 1'b1;
        else if (!rbusy) begin
          if (state_r == ST_BLOCK) state_nxt = in_msg_r ? ST_IDLE : ST_TAIL1;
          else if (state_r == ST_TAIL1 && len >= SplitAt) state_nxt = ST_TAIL2;
          else state_nxt = ST_OUT;
        end
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r <= '0;
      decl_r <= '0;
      in_msg_r <= 1'b0;
      out_valid_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      started_r <= (state_nxt == state_r) && (ctl.start || started_r) &&
                   (state_r != ST_IDLE);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept) begin
        seen_r <= seen_nxt;
        if (!in_msg_r) decl_r <= in_data.message_length;
        // A last byte that also closes a block is marked by clearing in_msg early;
        // the block state then continues to the tail.
        in_msg_r <= !in_data.last_byte;
      end
      if (state_r == ST_OUT) out_valid_r <= 1'b1;
    end
  end

  // Result register; a mismatch is decided when the last byte is taken.
  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      out_r.length_mismatch <= seen_nxt != (in_msg_r ? decl_r : in_data.message_length);
      out_r.digest_low <= '0;
      out_r.digest_high <= '0;
    end else if (state_r == ST_OUT && !out_r.length_mismatch) begin
      out_r.digest_low <= chain[63:0];
      out_r.digest_high <= chain[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r[wpos[5:2]][8*wpos[1:0] +: 8] <= in_data.data_byte;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(accept && state_r != ST_IDLE))
    else $error("byte taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n) !(state_r == ST_OUT && out_valid_r))
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n) !(rbusy && state_r == ST_IDLE))
    else $error("round unit busy while idle");

endmodule

### test/container_md5_hash_tb.sv
// Testbench for the container MD5 hash engine: directed table, then random messages.
`timescale 1ns / 100ps

module container_md5_hash_tb;
  import cmd5_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  container_md5_hash dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Hash state of the predictor, kept apart from the block.
  logic [31:0] hash_chain [4];
  logic [31:0] hash_buf [16];
  logic [31:0] hash_count;
  logic [31:0] hash_declared;
  logic        hash_open;

  out_item_t digest_queue [$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Round constants are written out here as a table rather than taken from the package functions.
  logic [31:0] md5_k [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
    32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
    32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
    32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
    32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
    32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
    32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8e0ccc92,
    32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
    32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
  int md5_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic void load_iv();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hefcdab89;
    hash_chain[2] = 32'h98badcfe;
    hash_chain[3] = 32'h10325476;
  endfunction

  function automatic void md5_compress(input logic [31:0] w [16]);
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = a + f + md5_k[i] + w[g];
      a = d; d = c; c = b;
      b = b + ((t << md5_s[(i / 16) * 4 + i % 4]) | (t >> (32 - md5_s[(i / 16) * 4 + i % 4])));
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
  endfunction

  // Takes one accepted byte; returns 1 with the digest or mismatch flag when it ends a message.
  function automatic bit hash_byte(input in_item_t it, output out_item_t res);
    logic [31:0] tail [16];
    logic [31:0] nbits, kword;
    int len, p;
    res = '0;
    if (!hash_open) begin
      load_iv();
      hash_count = '0;
      hash_declared = it.message_length;
      hash_open = 1'b1;
    end
    p = hash_count[5:0];
    hash_buf[p / 4][(p % 4) * 8 +: 8] = it.data_byte;
    hash_count += 1;
    if (hash_count[5:0] == 0) md5_compress(hash_buf);
    if (!it.last_byte) return 0;
    hash_open = 1'b0;
    if (hash_count != hash_declared) begin
      res.length_mismatch = 1'b1;
      return 1;
    end
    nbits = hash_count * 8;
    kword = (nbits >> 2) | 1;
    len = hash_count[5:0];
    foreach (tail[i]) tail[i] = '0;
    // Tail bytes are shifted by four when the bit count leads the block.
    p = (len >= 56) ? 0 : 4;
    for (int i = 0; i < len; i++)
      tail[(i + p) / 4][((i + p) % 4) * 8 +: 8] = hash_buf[i / 4][(i % 4) * 8 +: 8];
    tail[(len + p) / 4][((len + p) % 4) * 8 +: 8] = 8'h80;
    if (len >= 56) begin
      md5_compress(tail);
      foreach (tail[i]) tail[i] = '0;
    end
    tail[0] = nbits;
    tail[15] = kword;
    md5_compress(tail);
    res.digest_low = {hash_chain[1], hash_chain[0]};
    res.digest_high = {hash_chain[3], hash_chain[2]};
    return 1;
  endfunction

  // Drives one transaction from the falling edge and returns at the falling edge after
  // it is accepted; valid stays high until the next transaction or an idle cycle.
  task automatic send_byte(input in_item_t it);
    out_item_t res;
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hash_byte(it, res)) digest_queue.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_message(input int n, input logic [31:0] declared, input int fill);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      it.message_length = declared;
      it.last_byte = (i == n - 1);
      send_byte(it);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (digest_queue.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stall at each falling edge, check at each rising edge.
  always @(negedge clk)
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = digest_queue.pop_front();
        if (out_data.digest_low !== want.digest_low) begin
          $display("%0t: digest_low expected %h actual %h", $time, want.digest_low,
                   out_data.digest_low);
          error_count++;
        end
        if (out_data.digest_high !== want.digest_high) begin
          $display("%0t: digest_high expected %h actual %h", $time, want.digest_high,
                   out_data.digest_high);
          error_count++;
        end
        if (out_data.length_mismatch !== want.length_mismatch) begin
          $display("%0t: length_mismatch expected %b actual %b", $time,
                   want.length_mismatch, out_data.length_mismatch);
          error_count++;
        end
      end
    end
  end

  // Directed table: each row is a message of count bytes with a declared length.
  typedef struct {
    int          count;
    logic [31:0] declared;
    int          fill;     // fixed byte value, or -1 for random bytes
  } msg_row_t;

  msg_row_t directed [] = '{
    '{1, 32'd1, 0},            // shortest message, all-zero byte
    '{1, 32'd1, 255},          // shortest message, all-ones byte
    '{1, 32'hffffffff, -1},    // largest declared length gives a mismatch
    '{2, 32'd1, -1},           // more bytes than declared
    '{3, 32'd0, -1},           // zero declared length is a mismatch
    '{55, 32'd55, -1},         // longest tail that fits one block
    '{56, 32'd56, 170},        // shortest tail that splits
    '{63, 32'd63, 85},
    '{64, 32'd64, -1},         // exactly one full block, empty tail
    '{65, 32'd65, -1},
    '{120, 32'd120, -1},       // full block plus split tail
    '{128, 32'd128, -1},
    '{130, 32'd130, 255}
  };

  initial begin
    int len;
    load_iv();
    hash_open = 1'b0;
    hash_count = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) send_message(directed[r].count, directed[r].declared, directed[r].fill);
    drain();

    // Random messages in four idle/stall phases; the sender waits for all results between phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 49) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 49) : 0;
      for (int m = 0; m < 6; m++) begin
        // Mostly short messages; now and then one that crosses blocks.
        len = ($urandom_range(5) == 0) ? $urandom_range(140, 1) : $urandom_range(20, 1);
        if ($urandom_range(7) == 0)
          send_message(len, $urandom_range(3) == 0 ? $urandom : len + $urandom_range(2) - 1, -1);
        else
          send_message(len, len, -1);
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (400) @(negedge clk);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/cmd5_pkg.sv
rtl/cmd5_round.sv
rtl/container_md5_hash.sv
test/container_md5_hash_tb.sv
